>>> rtl/erpv_pkg.sv
package erpv_pkg;

    localparam int LEN_W    = 25;
    localparam int CHUNK_W  = 13;
    localparam int ENT_W    = 23;
    localparam int CNT11_W  = 11;
    localparam int PHASE_W  = 4;
    localparam int FCNT_W   = 6;
    localparam int CFG_IX_W = 2;

    localparam logic [LEN_W-1:0]   MAX_REGION_BYTES       = 25'd16777216;
    localparam logic [LEN_W-1:0]   CONSUMED_SAT           = MAX_REGION_BYTES + 25'd1;
    localparam logic [31:0]        MAX_CHUNKS_PER_REGION  = 32'd4096;
    localparam logic [31:0]        MAX_ENTITIES_PER_CHUNK = 32'd1024;
    localparam logic [31:0]        MAX_STRING_BYTES       = 32'd1024;
    localparam logic [31:0]        REGION_MAGIC           = 32'h52474531;
    localparam logic [FCNT_W-1:0]  COORD_BYTES            = 6'd12;
    localparam logic [FCNT_W-1:0]  ENTITY_FIXED_BYTES     = 6'd52;
    localparam logic [FCNT_W-1:0]  HALF_WORD_BYTES        = 6'd2;
    localparam logic [FCNT_W-1:0]  WORD_BYTES             = 6'd4;

    localparam logic [1:0] VERDICT_VALID        = 2'd0;
    localparam logic [1:0] VERDICT_INVALID      = 2'd1;
    localparam logic [1:0] VERDICT_CHUNK_LIMIT  = 2'd2;
    localparam logic [1:0] VERDICT_ENTITY_LIMIT = 2'd3;

    localparam logic [CFG_IX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_CHUNK_LIMIT    = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_ENTITY_LIMIT   = 2'd2;

    localparam int RESULT_W = 2 + LEN_W + CHUNK_W + ENT_W + LEN_W;

    typedef struct packed {
        logic [LEN_W-1:0]   string_byte_total;
        logic [ENT_W-1:0]   entity_total;
        logic [CHUNK_W-1:0] chunk_total;
        logic [LEN_W-1:0]   encoded_bytes;
        logic [1:0]         verdict;
    } t_result;

endpackage

>>> rtl/erpv_core.sv
module erpv_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    input  logic [erpv_pkg::LEN_W-1:0]    i_payload_length,
    input  logic [erpv_pkg::CHUNK_W-1:0]  i_chunk_limit,
    input  logic [erpv_pkg::ENT_W-1:0]    i_entity_limit,
    output erpv_pkg::t_result             o_result
);

    localparam logic [3:0] PH_MAGIC    = 4'd0;
    localparam logic [3:0] PH_VERSION  = 4'd1;
    localparam logic [3:0] PH_RESERVED = 4'd2;
    localparam logic [3:0] PH_CHUNKS   = 4'd3;
    localparam logic [3:0] PH_COORD    = 4'd4;
    localparam logic [3:0] PH_ENTS     = 4'd5;
    localparam logic [3:0] PH_S1LEN    = 4'd6;
    localparam logic [3:0] PH_S1BODY   = 4'd7;
    localparam logic [3:0] PH_FIXED    = 4'd8;
    localparam logic [3:0] PH_S2LEN    = 4'd9;
    localparam logic [3:0] PH_S2BODY   = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    logic [erpv_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [erpv_pkg::FCNT_W-1:0]  r_fcnt, n_fcnt;
    logic [31:0]                  r_shift, n_shift;
    logic [erpv_pkg::LEN_W-1:0]   r_consumed, n_consumed;
    logic [erpv_pkg::CNT11_W-1:0] r_str_left, n_str_left;
    logic [erpv_pkg::CHUNK_W-1:0] r_chunks_left, n_chunks_left;
    logic [erpv_pkg::CNT11_W-1:0] r_ents_left, n_ents_left;
    logic                         r_decided, n_decided;
    logic [1:0]                   r_verdict, n_verdict;
    logic [erpv_pkg::LEN_W-1:0]   r_enc, n_enc;
    logic [erpv_pkg::CHUNK_W-1:0] r_chunk_tot, n_chunk_tot;
    logic [erpv_pkg::ENT_W-1:0]   r_ent_tot, n_ent_tot;
    logic [erpv_pkg::LEN_W-1:0]   r_str_tot, n_str_tot;

    logic [erpv_pkg::LEN_W-1:0]   consumed_inc;
    logic [erpv_pkg::LEN_W-1:0]   rem;
    logic [31:0]                  word;
    logic [erpv_pkg::FCNT_W-1:0]  fcnt_inc;
    logic [erpv_pkg::FCNT_W-1:0]  need;
    logic [16:0]                  chunk_min;
    logic [16:0]                  ent_min;
    logic [erpv_pkg::ENT_W:0]     ent_sum;
    logic                         str_bad;
    logic [erpv_pkg::CNT11_W-1:0] ents_dec;
    logic [erpv_pkg::CHUNK_W-1:0] chunks_dec;
    logic                         len_bad;

    assign consumed_inc = (r_consumed < erpv_pkg::CONSUMED_SAT) ?
                          r_consumed + erpv_pkg::LEN_W'(1) : r_consumed;
    assign rem          = (i_payload_length > consumed_inc) ?
                          i_payload_length - consumed_inc : '0;
    assign word         = {r_shift[23:0], i_byte};
    assign fcnt_inc     = r_fcnt + erpv_pkg::FCNT_W'(1);
    assign chunk_min    = {word[12:0], 4'b0000};
    // w * 60 = w * 64 - w * 4
    assign ent_min      = {word[10:0], 6'b0} - {4'b0, word[10:0], 2'b00};
    assign ent_sum      = {1'b0, r_ent_tot} + {13'b0, word[10:0]};
    assign str_bad      = (word > erpv_pkg::MAX_STRING_BYTES) || (word > {7'b0, rem});
    assign ents_dec     = r_ents_left - erpv_pkg::CNT11_W'(1);
    assign chunks_dec   = r_chunks_left - erpv_pkg::CHUNK_W'(1);
    assign len_bad      = (i_payload_length > erpv_pkg::MAX_REGION_BYTES) ||
                          (consumed_inc != i_payload_length);

    always_comb begin
        case (r_phase)
            PH_VERSION, PH_RESERVED: need = erpv_pkg::HALF_WORD_BYTES;
            PH_COORD:                need = erpv_pkg::COORD_BYTES;
            PH_FIXED:                need = erpv_pkg::ENTITY_FIXED_BYTES;
            default:                 need = erpv_pkg::WORD_BYTES;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_fcnt        = r_fcnt;
        n_shift       = r_shift;
        n_consumed    = consumed_inc;
        n_str_left    = r_str_left;
        n_chunks_left = r_chunks_left;
        n_ents_left   = r_ents_left;
        n_decided     = r_decided;
        n_verdict     = r_verdict;
        n_enc         = r_enc;
        n_chunk_tot   = r_chunk_tot;
        n_ent_tot     = r_ent_tot;
        n_str_tot     = r_str_tot;

        if (!r_decided) begin
            if (r_phase == PH_DONE) begin
                n_decided = 1'b1;
                n_verdict = erpv_pkg::VERDICT_INVALID;
            end else if (r_phase == PH_S1BODY || r_phase == PH_S2BODY) begin
                n_str_left = r_str_left - erpv_pkg::CNT11_W'(1);
                if (n_str_left == '0) begin
                    n_fcnt  = '0;
                    n_shift = '0;
                    if (r_phase == PH_S1BODY) begin
                        n_phase = PH_FIXED;
                    end else begin
                        n_ents_left = ents_dec;
                        if (ents_dec != '0)           n_phase = PH_S1LEN;
                        else if (r_chunks_left != '0) n_phase = PH_COORD;
                        else                          n_phase = PH_DONE;
                    end
                end
            end else if (fcnt_inc < need) begin
                n_shift = word;
                n_fcnt  = fcnt_inc;
            end else begin
                // field complete: every path below either advances or decides
                n_shift = word;
                n_fcnt  = fcnt_inc;
                case (r_phase)
                    PH_MAGIC: begin
                        if (word != erpv_pkg::REGION_MAGIC) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_phase = PH_VERSION;
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    PH_VERSION: begin
                        if (word[15:0] != 16'd1) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_phase = PH_RESERVED;
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    PH_RESERVED: begin
                        if (word[15:0] != 16'd0) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_phase = PH_CHUNKS;
                            n_fcnt  = '0;
                            n_shift = '0;
                        end
                    end
                    PH_CHUNKS: begin
                        if (word > erpv_pkg::MAX_CHUNKS_PER_REGION) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else if (word > {19'b0, i_chunk_limit}) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_CHUNK_LIMIT;
                        end else if ({8'b0, chunk_min} > rem) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_enc         = i_payload_length;
                            n_chunk_tot   = word[12:0];
                            n_chunks_left = word[12:0];
                            n_phase       = (word[12:0] != '0) ? PH_COORD : PH_DONE;
                            n_fcnt        = '0;
                            n_shift       = '0;
                        end
                    end
                    PH_COORD: begin
                        n_phase = PH_ENTS;
                        n_fcnt  = '0;
                        n_shift = '0;
                    end
                    PH_ENTS: begin
                        if (word > erpv_pkg::MAX_ENTITIES_PER_CHUNK) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else if (ent_sum > {1'b0, i_entity_limit}) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_ENTITY_LIMIT;
                        end else if ({8'b0, ent_min} > rem) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_ent_tot     = ent_sum[erpv_pkg::ENT_W-1:0];
                            n_ents_left   = word[10:0];
                            n_chunks_left = chunks_dec;
                            n_fcnt        = '0;
                            n_shift       = '0;
                            if (word[10:0] != '0)      n_phase = PH_S1LEN;
                            else if (chunks_dec != '0) n_phase = PH_COORD;
                            else                       n_phase = PH_DONE;
                        end
                    end
                    PH_S1LEN: begin
                        if (str_bad) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_str_tot  = r_str_tot + {14'b0, word[10:0]};
                            n_str_left = word[10:0];
                            n_phase    = (word[10:0] != '0) ? PH_S1BODY : PH_FIXED;
                            n_fcnt     = '0;
                            n_shift    = '0;
                        end
                    end
                    PH_FIXED: begin
                        n_phase = PH_S2LEN;
                        n_fcnt  = '0;
                        n_shift = '0;
                    end
                    PH_S2LEN: begin
                        if (str_bad) begin
                            n_decided = 1'b1;
                            n_verdict = erpv_pkg::VERDICT_INVALID;
                        end else begin
                            n_str_tot  = r_str_tot + {14'b0, word[10:0]};
                            n_str_left = word[10:0];
                            n_fcnt     = '0;
                            n_shift    = '0;
                            if (word[10:0] != '0) begin
                                n_phase = PH_S2BODY;
                            end else begin
                                // empty second string closes the entity
                                n_ents_left = ents_dec;
                                if (ents_dec != '0)           n_phase = PH_S1LEN;
                                else if (r_chunks_left != '0) n_phase = PH_COORD;
                                else                          n_phase = PH_DONE;
                            end
                        end
                    end
                    default: begin
                        n_decided = 1'b1;
                        n_verdict = erpv_pkg::VERDICT_INVALID;
                    end
                endcase
            end
        end

        if (len_bad) begin
            o_result = '0;
            o_result.verdict = erpv_pkg::VERDICT_INVALID;
        end else begin
            o_result.verdict           = n_decided ? n_verdict :
                                         ((n_phase == PH_DONE) ? erpv_pkg::VERDICT_VALID :
                                                                 erpv_pkg::VERDICT_INVALID);
            o_result.encoded_bytes     = n_enc;
            o_result.chunk_total       = n_chunk_tot;
            o_result.entity_total      = n_ent_tot;
            o_result.string_byte_total = n_str_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase       <= PH_MAGIC;
            r_fcnt        <= '0;
            r_shift       <= '0;
            r_consumed    <= '0;
            r_str_left    <= '0;
            r_chunks_left <= '0;
            r_ents_left   <= '0;
            r_decided     <= 1'b0;
            r_verdict     <= erpv_pkg::VERDICT_VALID;
            r_enc         <= '0;
            r_chunk_tot   <= '0;
            r_ent_tot     <= '0;
            r_str_tot     <= '0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_fcnt        <= n_fcnt;
            r_shift       <= n_shift;
            r_consumed    <= n_consumed;
            r_str_left    <= n_str_left;
            r_chunks_left <= n_chunks_left;
            r_ents_left   <= n_ents_left;
            r_decided     <= n_decided;
            r_verdict     <= n_verdict;
            r_enc         <= n_enc;
            r_chunk_tot   <= n_chunk_tot;
            r_ent_tot     <= n_ent_tot;
            r_str_tot     <= n_str_tot;
        end
    end

endmodule

>>> rtl/entity_region_payload_validator.sv
// Channel   | Dir | Payload
// ----------+-----+---------------------------------------------------------------
// s_axis    | in  | tdata[7:0] data_byte; tlast last_byte
// m_axis    | out | tdata: verdict, encoded_bytes, chunk_total, entity_total,
//           |     |        string_byte_total (one transfer per payload, on last byte)
// i_cfg_*   | in  | 0 payload_length, 1 chunk_limit, 2 entity_limit
//
// One payload byte per cycle, sustained. A byte passes an input register, the
// parser updates its state from it as it leaves that register, and the result of
// a last byte is loaded into the result register as that byte leaves, which raises
// m_axis_tvalid. i_rst_n is synchronous and clears parse state and the registers
// to their defaults. A pending result stalls only a following last byte.
module entity_region_payload_validator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] verdict, [26:2] encoded_bytes, [39:27] chunk_total,
    // [62:40] entity_total, [87:63] string_byte_total
    output logic [erpv_pkg::RESULT_W-1:0]       m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [erpv_pkg::CFG_IX_W-1:0]       i_cfg_index,
    input  logic [erpv_pkg::LEN_W-1:0]          i_cfg_data
);

    logic [erpv_pkg::LEN_W-1:0]   r_payload_length;
    logic [erpv_pkg::CHUNK_W-1:0] r_chunk_limit;
    logic [erpv_pkg::ENT_W-1:0]   r_entity_limit;

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_last;
    logic                         r_out_valid;
    erpv_pkg::t_result            r_out;

    erpv_pkg::t_result            core_result;
    logic                         out_free;
    logic                         advance;
    logic                         in_xfer;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= '0;
            r_chunk_limit    <= erpv_pkg::CHUNK_W'(4096);
            r_entity_limit   <= erpv_pkg::ENT_W'(4194304);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                erpv_pkg::CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_data;
                erpv_pkg::CFG_CHUNK_LIMIT:    r_chunk_limit    <= i_cfg_data[erpv_pkg::CHUNK_W-1:0];
                erpv_pkg::CFG_ENTITY_LIMIT:   r_entity_limit   <= i_cfg_data[erpv_pkg::ENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    erpv_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (advance),
        .i_byte           (r_in_byte),
        .i_last           (r_in_last),
        .i_payload_length (r_payload_length),
        .i_chunk_limit    (r_chunk_limit),
        .i_entity_limit   (r_entity_limit),
        .o_result         (core_result)
    );

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= core_result;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int ITEM_COUNT       = 1950;
    localparam int RANDOM_RESULTS   = 6;
    localparam int MIN_CHUNK_BYTES  = 16;
    localparam int MIN_ENTITY_BYTES = 60;
    localparam logic [erpv_pkg::CFG_IX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        RP_MAGIC, RP_VERSION, RP_RESERVED, RP_CHUNKS, RP_COORD, RP_ENTS,
        RP_S1LEN, RP_S1BODY, RP_FIXED, RP_S2LEN, RP_S2BODY, RP_DONE
    } t_region_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_byte;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata = '0;   // [7:0] data_byte
    logic                                s_axis_tlast = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [1:0] verdict, [26:2] encoded_bytes, [39:27] chunk_total,
    // [62:40] entity_total, [87:63] string_byte_total
    logic [erpv_pkg::RESULT_W-1:0]       m_axis_tdata;
    logic                                i_cfg_we = 1'b0;
    logic [erpv_pkg::CFG_IX_W-1:0]       i_cfg_index = '0;
    logic [erpv_pkg::LEN_W-1:0]          i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    entity_region_payload_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Register copies, reset values of the block
    logic [erpv_pkg::LEN_W-1:0]   cfg_payload_len = '0;
    logic [erpv_pkg::CHUNK_W-1:0] cfg_chunk_lim   = 13'd4096;
    logic [erpv_pkg::ENT_W-1:0]   cfg_entity_lim  = 23'd4194304;

    // Parser state of the predictor
    t_region_phase                rp_phase;
    int                           rp_fcnt;
    logic [31:0]                  rp_shift;
    logic [erpv_pkg::LEN_W-1:0]   rp_consumed;
    logic [10:0]                  rp_str_left;
    logic [erpv_pkg::CHUNK_W-1:0] rp_chunks_left;
    logic [10:0]                  rp_ents_left;
    logic                         rp_decided;
    logic [1:0]                   rp_verdict;
    logic [erpv_pkg::LEN_W-1:0]   rp_enc;
    logic [erpv_pkg::CHUNK_W-1:0] rp_chunks;
    logic [erpv_pkg::ENT_W-1:0]   rp_ents;
    logic [erpv_pkg::LEN_W-1:0]   rp_strs;

    erpv_pkg::t_result  verdict_q[$];
    t_payload_byte      pending[$];
    logic [7:0]         frame[$];

    int                 bytes_queued = 0;
    int                 bytes_accepted = 0;
    int                 mismatches = 0;
    int                 cycles = 0;
    logic               byte_taken = 1'b0;
    int                 gap_left = 0;
    int                 burst_left = 0;
    logic [15:0]        rx_pat = 16'hFFFF;
    int                 rx_hold = 0;
    t_payload_byte      next_item;
    erpv_pkg::t_result  want_res;
    erpv_pkg::t_result  seen_res;

    task automatic rp_clear();
        rp_phase       = RP_MAGIC;
        rp_fcnt        = 0;
        rp_shift       = '0;
        rp_consumed    = '0;
        rp_str_left    = '0;
        rp_chunks_left = '0;
        rp_ents_left   = '0;
        rp_decided     = 1'b0;
        rp_verdict     = erpv_pkg::VERDICT_VALID;
        rp_enc         = '0;
        rp_chunks      = '0;
        rp_ents        = '0;
        rp_strs        = '0;
    endtask

    task automatic rp_enter(input t_region_phase p);
        rp_phase = p;
        rp_fcnt  = 0;
        rp_shift = '0;
    endtask

    task automatic rp_decide(input logic [1:0] v);
        rp_decided = 1'b1;
        rp_verdict = v;
    endtask

    task automatic rp_next_record();
        if (rp_ents_left != 0)
            rp_enter(RP_S1LEN);
        else if (rp_chunks_left != 0)
            rp_enter(RP_COORD);
        else
            rp_enter(RP_DONE);
    endtask

    task automatic rp_close_entity();
        rp_ents_left = rp_ents_left - 11'd1;
        rp_next_record();
    endtask

    task automatic rp_take_length(input logic [31:0] len,
                                  input logic [erpv_pkg::LEN_W-1:0] rem,
                                  input t_region_phase body, input t_region_phase nxt);
        if (len > erpv_pkg::MAX_STRING_BYTES || len > {7'b0, rem}) begin
            rp_decide(erpv_pkg::VERDICT_INVALID);
            return;
        end
        rp_strs     = rp_strs + len[erpv_pkg::LEN_W-1:0];
        rp_str_left = len[10:0];
        rp_enter((len != 0) ? body : nxt);
    endtask

    task automatic rp_parse_byte(input logic [7:0] b, input logic [erpv_pkg::LEN_W-1:0] rem);
        int          need;
        logic [31:0] w;
        logic [31:0] ent_room;
        if (rp_phase == RP_DONE) begin
            rp_decide(erpv_pkg::VERDICT_INVALID);
            return;
        end
        // string bodies are only counted down
        if (rp_phase == RP_S1BODY || rp_phase == RP_S2BODY) begin
            rp_str_left = rp_str_left - 11'd1;
            if (rp_str_left == 0) begin
                if (rp_phase == RP_S1BODY)
                    rp_enter(RP_FIXED);
                else
                    rp_close_entity();
            end
            return;
        end
        rp_shift = {rp_shift[23:0], b};
        rp_fcnt  = rp_fcnt + 1;
        case (rp_phase)
            RP_VERSION, RP_RESERVED: need = int'(erpv_pkg::HALF_WORD_BYTES);
            RP_COORD:                need = int'(erpv_pkg::COORD_BYTES);
            RP_FIXED:                need = int'(erpv_pkg::ENTITY_FIXED_BYTES);
            default:                 need = int'(erpv_pkg::WORD_BYTES);
        endcase
        if (rp_fcnt < need)
            return;
        w = rp_shift;
        case (rp_phase)
            RP_MAGIC: begin
                if (w != erpv_pkg::REGION_MAGIC) rp_decide(erpv_pkg::VERDICT_INVALID);
                else rp_enter(RP_VERSION);
            end
            RP_VERSION: begin
                if (w[15:0] != 16'd1) rp_decide(erpv_pkg::VERDICT_INVALID);
                else rp_enter(RP_RESERVED);
            end
            RP_RESERVED: begin
                if (w[15:0] != 16'd0) rp_decide(erpv_pkg::VERDICT_INVALID);
                else rp_enter(RP_CHUNKS);
            end
            RP_CHUNKS: begin
                if (w > erpv_pkg::MAX_CHUNKS_PER_REGION)
                    rp_decide(erpv_pkg::VERDICT_INVALID);
                else if (w > {19'b0, cfg_chunk_lim})
                    rp_decide(erpv_pkg::VERDICT_CHUNK_LIMIT);
                else if (64'(w) * 64'(MIN_CHUNK_BYTES) > 64'(rem))
                    rp_decide(erpv_pkg::VERDICT_INVALID);
                else begin
                    rp_enc         = cfg_payload_len;
                    rp_chunks      = w[erpv_pkg::CHUNK_W-1:0];
                    rp_chunks_left = w[erpv_pkg::CHUNK_W-1:0];
                    rp_enter((w != 0) ? RP_COORD : RP_DONE);
                end
            end
            RP_COORD: rp_enter(RP_ENTS);
            RP_ENTS: begin
                ent_room = {9'b0, cfg_entity_lim} - {9'b0, rp_ents};
                if (w > erpv_pkg::MAX_ENTITIES_PER_CHUNK)
                    rp_decide(erpv_pkg::VERDICT_INVALID);
                else if (rp_ents > cfg_entity_lim || w > ent_room)
                    rp_decide(erpv_pkg::VERDICT_ENTITY_LIMIT);
                else if (64'(w) * 64'(MIN_ENTITY_BYTES) > 64'(rem))
                    rp_decide(erpv_pkg::VERDICT_INVALID);
                else begin
                    rp_ents        = rp_ents + w[erpv_pkg::ENT_W-1:0];
                    rp_ents_left   = w[10:0];
                    rp_chunks_left = rp_chunks_left - 13'd1;
                    rp_next_record();
                end
            end
            RP_S1LEN: rp_take_length(w, rem, RP_S1BODY, RP_FIXED);
            RP_FIXED: rp_enter(RP_S2LEN);
            RP_S2LEN: begin
                rp_take_length(w, rem, RP_S2BODY, RP_S2LEN);
                if (!rp_decided && rp_phase == RP_S2LEN)
                    rp_close_entity();
            end
            default: rp_decide(erpv_pkg::VERDICT_INVALID);
        endcase
    endtask

    task automatic track_payload_byte(input logic [7:0] b, input logic last);
        logic [erpv_pkg::LEN_W-1:0] rem;
        erpv_pkg::t_result          res;
        if (rp_consumed < erpv_pkg::CONSUMED_SAT)
            rp_consumed = rp_consumed + erpv_pkg::LEN_W'(1);
        if (!rp_decided) begin
            rem = (cfg_payload_len > rp_consumed) ? cfg_payload_len - rp_consumed : '0;
            rp_parse_byte(b, rem);
        end
        if (last) begin
            res = '0;
            // a length disagreement overrides everything and zeroes the totals
            if (cfg_payload_len > erpv_pkg::MAX_REGION_BYTES ||
                rp_consumed != cfg_payload_len) begin
                res.verdict = erpv_pkg::VERDICT_INVALID;
            end else begin
                if (!rp_decided)
                    rp_verdict = (rp_phase == RP_DONE) ? erpv_pkg::VERDICT_VALID :
                                                         erpv_pkg::VERDICT_INVALID;
                res.verdict           = rp_verdict;
                res.encoded_bytes     = rp_enc;
                res.chunk_total       = rp_chunks;
                res.entity_total      = rp_ents;
                res.string_byte_total = rp_strs;
            end
            verdict_q.insert(verdict_q.size(), res);
            rp_clear();
        end
    endtask

    // Payload construction
    task automatic add_byte(input logic [7:0] b);
        frame.insert(frame.size(), b);
    endtask

    task automatic put_be(input logic [31:0] v, input int n);
        for (int k = n - 1; k >= 0; k--)
            add_byte(v[8*k +: 8]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic put_header(input logic [31:0] chunks);
        put_be(erpv_pkg::REGION_MAGIC, 4);
        put_be(32'd1, 2);
        put_be(32'd0, 2);
        put_be(chunks, 4);
    endtask

    task automatic put_string(input logic [31:0] len, input int body);
        put_be(len, 4);
        put_noise(body);
    endtask

    task automatic put_entity(input int s1, input int s2);
        put_string(s1, s1);
        put_noise(52);
        put_string(s2, s2);
    endtask

    task automatic put_chunk(input int ents, input int max_str);
        put_noise(12);
        put_be(ents, 4);
        repeat (ents) put_entity($urandom_range(0, max_str), $urandom_range(0, max_str));
    endtask

    task automatic build_region(input int nch, input int max_ents, input int max_str);
        frame.delete();
        put_header(nch);
        repeat (nch) put_chunk($urandom_range(0, max_ents), max_str);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (bytes_queued != bytes_accepted || verdict_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [erpv_pkg::CFG_IX_W-1:0] idx,
                             input logic [erpv_pkg::LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_frame();
        t_payload_byte item;
        foreach (frame[i]) begin
            item.data = frame[i];
            item.last = (i == frame.size() - 1);
            pending.insert(pending.size(), item);
        end
        bytes_queued += frame.size();
    endtask

    task automatic send_region(input logic [erpv_pkg::LEN_W-1:0] len);
        wait_idle();
        cfg_write(erpv_pkg::CFG_PAYLOAD_LENGTH, len);
        send_frame();
    endtask

    task automatic send_exact();
        send_region(erpv_pkg::LEN_W'(frame.size()));
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || byte_taken) begin
            if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                next_item      = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.data;
                s_axis_tlast  <= next_item.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotate a stall pattern, swap it now and then
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            case ($urandom_range(0, 3))
                0:       rx_pat <= 16'hFFFF;
                1:       rx_pat <= 16'($urandom) | 16'h0001;
                2:       rx_pat <= 16'h0101;
                default: rx_pat <= 16'hAAAA;
            endcase
            rx_hold <= $urandom_range(16, 300);
        end else begin
            rx_pat  <= {rx_pat[0], rx_pat[15:1]};
            rx_hold <= rx_hold - 1;
        end
        m_axis_tready <= rx_pat[0];
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Monitor: follow register writes and byte transfers, check results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    erpv_pkg::CFG_PAYLOAD_LENGTH: cfg_payload_len = i_cfg_data;
                    erpv_pkg::CFG_CHUNK_LIMIT:
                        cfg_chunk_lim  = i_cfg_data[erpv_pkg::CHUNK_W-1:0];
                    erpv_pkg::CFG_ENTITY_LIMIT:
                        cfg_entity_lim = i_cfg_data[erpv_pkg::ENT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_payload_byte(s_axis_tdata, s_axis_tlast);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_res = erpv_pkg::t_result'(m_axis_tdata);
                if (verdict_q.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want_res = verdict_q.pop_front();
                    if (seen_res.verdict != want_res.verdict) begin
                        $error("verdict: expected %0d, got %0d",
                               want_res.verdict, seen_res.verdict);
                        mismatches++;
                    end
                    if (seen_res.encoded_bytes != want_res.encoded_bytes) begin
                        $error("encoded_bytes: expected %0d, got %0d",
                               want_res.encoded_bytes, seen_res.encoded_bytes);
                        mismatches++;
                    end
                    if (seen_res.chunk_total != want_res.chunk_total) begin
                        $error("chunk_total: expected %0d, got %0d",
                               want_res.chunk_total, seen_res.chunk_total);
                        mismatches++;
                    end
                    if (seen_res.entity_total != want_res.entity_total) begin
                        $error("entity_total: expected %0d, got %0d",
                               want_res.entity_total, seen_res.entity_total);
                        mismatches++;
                    end
                    if (seen_res.string_byte_total != want_res.string_byte_total) begin
                        $error("string_byte_total: expected %0d, got %0d",
                               want_res.string_byte_total, seen_res.string_byte_total);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        logic [erpv_pkg::LEN_W-1:0] len_pick;
        logic [erpv_pkg::LEN_W-1:0] lim_pick;
        int                         keep;
        int                         reps;
        int                         rnd_results;
        rnd_results = 0;
        rp_clear();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // well-formed: empty region, then one chunk with empty and short strings
        build_region(0, 0, 0);
        send_exact();
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(2, 4);
        put_string(0, 0);
        repeat (52) add_byte(8'hFF);
        put_string(3, 3);
        put_string(5, 5);
        repeat (52) add_byte(8'h00);
        put_string(0, 0);
        send_exact();

        // header word errors
        frame.delete();
        put_be(erpv_pkg::REGION_MAGIC ^ 32'h1, 4);
        put_be(32'd1, 2);
        put_be(32'd0, 2);
        put_be(32'd0, 4);
        send_exact();
        frame.delete();
        put_be(erpv_pkg::REGION_MAGIC, 4);
        put_be(32'd2, 2);
        put_be(32'd0, 2);
        put_be(32'd0, 4);
        send_exact();
        frame.delete();
        put_be(erpv_pkg::REGION_MAGIC, 4);
        put_be(32'd1, 2);
        put_be(32'h8000, 2);
        put_be(32'd0, 4);
        send_exact();

        // chunk count: hard maximum, caller limit, room left
        frame.delete();
        put_header(32'd4097);
        put_noise(20);
        send_exact();
        frame.delete();
        put_header(32'hFFFF_FFFF);
        send_exact();
        frame.delete();
        put_header(32'd4096);
        put_noise(40);
        send_exact();
        wait_idle();
        cfg_write(erpv_pkg::CFG_CHUNK_LIMIT, 25'd1);
        build_region(2, 1, 2);
        send_exact();
        wait_idle();
        cfg_write(erpv_pkg::CFG_CHUNK_LIMIT, 25'd0);
        build_region(0, 0, 0);
        send_exact();
        build_region(1, 0, 0);
        send_exact();
        wait_idle();
        cfg_write(erpv_pkg::CFG_CHUNK_LIMIT, 25'd4096);

        // entity count: hard maximum, room left, caller limit
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(32'd1025, 4);
        put_noise(8);
        send_exact();
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(32'd1024, 4);
        put_noise(8);
        send_exact();
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(32'd2, 4);
        put_entity(1, 1);
        send_exact();
        wait_idle();
        cfg_write(erpv_pkg::CFG_ENTITY_LIMIT, 25'd1);
        frame.delete();
        put_header(2);
        put_chunk(1, 2);
        put_chunk(1, 2);
        send_exact();
        wait_idle();
        cfg_write(erpv_pkg::CFG_ENTITY_LIMIT, 25'd0);
        frame.delete();
        put_header(1);
        put_chunk(1, 0);
        send_exact();
        wait_idle();
        cfg_write(erpv_pkg::CFG_ENTITY_LIMIT, 25'd4194304);

        // string length: above the maximum, beyond the payload, exactly what is left
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(32'd1, 4);
        put_string(32'd1025, 4);
        put_noise(52);
        send_exact();
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(32'd1, 4);
        put_string(32'd100, 10);
        put_noise(52);
        put_string(0, 0);
        send_exact();
        frame.delete();
        put_header(1);
        put_noise(12);
        put_be(32'd1, 4);
        put_string(32'd56, 56);
        send_exact();

        // surplus byte, truncation
        build_region(1, 1, 3);
        add_byte(8'h00);
        send_exact();
        build_region(1, 2, 3);
        repeat (5) void'(frame.pop_back());
        send_exact();

        // length register disagrees with the last mark, or is out of range
        build_region(1, 1, 2);
        send_region(erpv_pkg::LEN_W'(frame.size() + 1));
        build_region(1, 1, 2);
        send_region(erpv_pkg::LEN_W'(frame.size() - 1));
        frame.delete();
        add_byte(8'h52);
        send_region('0);
        build_region(0, 0, 0);
        send_region(erpv_pkg::MAX_REGION_BYTES);
        build_region(0, 0, 0);
        send_region(25'h1FF_FFFF);

        // unused index must not alias a register
        wait_idle();
        cfg_write(CFG_UNUSED, '0);
        build_region(1, 1, 2);
        send_exact();

        // same payload back to back, last bytes close together
        build_region(1, 1, 2);
        send_exact();
        send_frame();
        send_frame();

        while (bytes_queued < ITEM_COUNT || rnd_results < RANDOM_RESULTS) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                case ($urandom_range(0, 4))
                    0:       lim_pick = '0;
                    1:       lim_pick = erpv_pkg::LEN_W'($urandom_range(1, 2));
                    2:       lim_pick = 25'd4096;
                    3:       lim_pick = 25'h1FFF;
                    default: lim_pick = erpv_pkg::LEN_W'($urandom);
                endcase
                cfg_write(erpv_pkg::CFG_CHUNK_LIMIT, lim_pick);
                case ($urandom_range(0, 4))
                    0:       lim_pick = '0;
                    1:       lim_pick = erpv_pkg::LEN_W'($urandom_range(1, 4));
                    2:       lim_pick = 25'd4194304;
                    3:       lim_pick = 25'h7F_FFFF;
                    default: lim_pick = erpv_pkg::LEN_W'($urandom);
                endcase
                cfg_write(erpv_pkg::CFG_ENTITY_LIMIT, lim_pick);
            end
            build_region($urandom_range(0, 2), $urandom_range(0, 2),
                         ($urandom_range(0, 4) == 0) ? 40 : 4);
            len_pick = erpv_pkg::LEN_W'(frame.size());
            case ($urandom_range(0, 9))
                5: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
                6: begin
                    keep = $urandom_range(1, frame.size() - 1);
                    while (frame.size() > keep) void'(frame.pop_back());
                    len_pick = erpv_pkg::LEN_W'(keep);
                end
                7: begin
                    put_noise($urandom_range(1, 4));
                    len_pick = erpv_pkg::LEN_W'(frame.size());
                end
                8: begin
                    if ($urandom_range(0, 1) == 0)
                        len_pick = erpv_pkg::LEN_W'(frame.size() + 1);
                    else
                        len_pick = erpv_pkg::LEN_W'($urandom);
                end
                9: begin
                    frame.delete();
                    if ($urandom_range(0, 1) == 0)
                        put_be(erpv_pkg::REGION_MAGIC, 4);
                    put_noise($urandom_range(1, 20));
                    len_pick = erpv_pkg::LEN_W'(frame.size());
                end
                default: ;
            endcase
            reps = $urandom_range(1, 3);
            send_region(len_pick);
            // repeat at the same length, now and then with one byte changed
            for (int r = 1; r < reps; r++) begin
                if ($urandom_range(0, 1) == 0)
                    frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
                send_frame();
            end
            rnd_results += reps;
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/erpv_pkg.sv
rtl/erpv_core.sv
rtl/entity_region_payload_validator.sv
tb/testbench.sv
